// File: sv/bdsm_pkg.sv
// Shared widths and types for the radix 2^52 multiply-by-word datapath.
// Standalone package; used by bignum_digit_scalar_multiply.
package bdsm_pkg;

    localparam int DIGIT_W     = 52;
    localparam int HALF_W      = DIGIT_W / 2;
    localparam int IN_TDATA_W  = 2 * DIGIT_W;
    localparam int OUT_TDATA_W = ((DIGIT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - DIGIT_W;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [DIGIT_W:0]   digit_carry_t;
    typedef logic [HALF_W-1:0]  half_t;

endpackage

// File: sv/bignum_digit_scalar_multiply.sv
// Big integer (radix 2^52, least significant digit first) times one 52-bit word.
// Depends on bdsm_pkg for widths and digit types.
//
// A digit accepted on the slave side passes the input, partial-product and product
// registers into the output register; the extra top digit of a number follows one beat later.
// Throughput: one input beat per cycle while the output is not stalled; the beat flagged
// tlast produces two output beats, and no new result commits while its top digit waits.
// The top digit register is the only place a second result waits; upstream stages collapse bubbles.
// Reset (rst_n low, asynchronous): all stage valids drop, the pending carry digit
// clears to zero, and the output port goes idle.
module bignum_digit_scalar_multiply
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Slave side
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [bdsm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // in_digit[51:0], multiplier[103:52]
    input  logic                               s_axis_tlast,   // last_digit
    // Master side
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [bdsm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // out_digit[51:0], zero pad[55:52]
    output logic                               m_axis_tlast    // out_last
);

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic                 s1_valid_reg;
    bdsm_pkg::digit_t     s1_digit_reg;
    bdsm_pkg::digit_t     s1_mult_reg;
    logic                 s1_last_reg;

    // Stage 2: four 26x26 partial products
    logic                 s2_valid_reg;
    bdsm_pkg::digit_t     s2_p00_reg;
    bdsm_pkg::digit_t     s2_p01_reg;
    bdsm_pkg::digit_t     s2_p10_reg;
    bdsm_pkg::digit_t     s2_p11_reg;
    logic                 s2_last_reg;

    // Stage 3: full product split into low and high digits
    logic                 s3_valid_reg;
    bdsm_pkg::digit_t     s3_lo_reg;
    bdsm_pkg::digit_t     s3_hi_reg;
    logic                 s3_last_reg;

    // Stage 4: carry accumulation and output beat, plus the held top digit
    bdsm_pkg::digit_t     pending_reg;
    bdsm_pkg::digit_t     pending_next;
    logic                 out_valid_reg;
    bdsm_pkg::digit_t     out_digit_reg;
    logic                 out_last_reg;
    logic                 top_valid_reg;
    bdsm_pkg::digit_t     top_digit_reg;

    // Handshake and flow control
    logic                 s1_ready;
    logic                 s2_ready;
    logic                 s3_ready;
    logic                 out_fire;
    logic                 commit;

    // Datapath intermediates
    bdsm_pkg::half_t      a0;
    bdsm_pkg::half_t      a1;
    bdsm_pkg::half_t      b0;
    bdsm_pkg::half_t      b1;
    bdsm_pkg::digit_carry_t mid;
    bdsm_pkg::digit_carry_t t_sum;
    bdsm_pkg::digit_t     hi_next;
    bdsm_pkg::digit_carry_t acc_sum;
    bdsm_pkg::digit_t     carry_out;

    // ------------------------------------------------------------------
    // Flow control: a stage takes new data when it is empty or its
    // successor takes its current content this cycle.
    // ------------------------------------------------------------------
    assign out_fire = out_valid_reg && m_axis_tready;

    // The accumulator commits only when the output slot frees and no top
    // digit is queued behind the current beat.
    assign commit   = s3_valid_reg && !top_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s3_ready = !s3_valid_reg || commit;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;

    assign s_axis_tready = s1_ready;

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    assign a0 = s1_digit_reg[bdsm_pkg::HALF_W-1:0];
    assign a1 = s1_digit_reg[bdsm_pkg::DIGIT_W-1:bdsm_pkg::HALF_W];
    assign b0 = s1_mult_reg[bdsm_pkg::HALF_W-1:0];
    assign b1 = s1_mult_reg[bdsm_pkg::DIGIT_W-1:bdsm_pkg::HALF_W];

    // Combine partials: mid terms straddle the digit boundary.
    assign mid   = {1'b0, s2_p01_reg} + {1'b0, s2_p10_reg};
    assign t_sum = {1'b0, s2_p00_reg}
                 + {1'b0, mid[bdsm_pkg::HALF_W-1:0], {bdsm_pkg::HALF_W{1'b0}}};
    assign hi_next = s2_p11_reg
                   + bdsm_pkg::digit_t'(mid[bdsm_pkg::DIGIT_W:bdsm_pkg::HALF_W])
                   + bdsm_pkg::digit_t'(t_sum[bdsm_pkg::DIGIT_W]);

    // Add the pending carry digit; high half plus carry becomes the new pending.
    // The high half never exceeds 2^52 - 2, so the increment cannot wrap.
    assign acc_sum   = {1'b0, s3_lo_reg} + {1'b0, pending_reg};
    assign carry_out = s3_hi_reg + bdsm_pkg::digit_t'(acc_sum[bdsm_pkg::DIGIT_W]);

    always_comb
    begin
        pending_next = pending_reg;
        if (commit)
        begin
            // Drop the carry at the end of a number; it leaves as the top digit.
            pending_next = s3_last_reg ? '0 : carry_out;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            top_valid_reg <= 1'b0;
            pending_reg   <= '0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            pending_reg <= pending_next;

            if (commit)
            begin
                out_valid_reg <= 1'b1;
                top_valid_reg <= s3_last_reg;
            end
            else if (out_fire)
            begin
                // Advance the queued top digit into the output slot.
                out_valid_reg <= top_valid_reg;
                top_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s1_ready && s_axis_tvalid)
        begin
            s1_digit_reg <= s_axis_tdata[bdsm_pkg::DIGIT_W-1:0];
            s1_mult_reg  <= s_axis_tdata[bdsm_pkg::IN_TDATA_W-1:bdsm_pkg::DIGIT_W];
            s1_last_reg  <= s_axis_tlast;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_p00_reg  <= bdsm_pkg::digit_t'(a0) * bdsm_pkg::digit_t'(b0);
            s2_p01_reg  <= bdsm_pkg::digit_t'(a0) * bdsm_pkg::digit_t'(b1);
            s2_p10_reg  <= bdsm_pkg::digit_t'(a1) * bdsm_pkg::digit_t'(b0);
            s2_p11_reg  <= bdsm_pkg::digit_t'(a1) * bdsm_pkg::digit_t'(b1);
            s2_last_reg <= s1_last_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_lo_reg   <= t_sum[bdsm_pkg::DIGIT_W-1:0];
            s3_hi_reg   <= hi_next;
            s3_last_reg <= s2_last_reg;
        end
        if (commit)
        begin
            out_digit_reg <= acc_sum[bdsm_pkg::DIGIT_W-1:0];
            out_last_reg  <= 1'b0;
            top_digit_reg <= carry_out;
        end
        else if (out_fire && top_valid_reg)
        begin
            out_digit_reg <= top_digit_reg;
            out_last_reg  <= 1'b1;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{bdsm_pkg::OUT_PAD_W{1'b0}}, out_digit_reg};
    assign m_axis_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A queued top digit always sits behind a live output beat.
    a_top_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        top_valid_reg |-> out_valid_reg)
        else $error("top digit queued with empty output slot");

    // Taking a beat while a top digit waits presents that digit as the last beat.
    a_top_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && top_valid_reg) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("top digit not presented after its low digit");

    // A last beat on the port means nothing is left queued behind it.
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> !top_valid_reg)
        else $error("top digit still queued behind last beat");

    // Committing the final digit of a number clears the pending carry.
    a_pending_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && s3_last_reg) |=> (pending_reg == '0))
        else $error("pending digit not cleared at end of number");

endmodule

// File: bench/tb.sv
// Self-checking bench for bignum_digit_scalar_multiply: directed digit table, then random
// numbers with random stalls on both stream sides. Depends on bdsm_pkg and the block only.
`timescale 1ns / 100ps

module tb;

    localparam bdsm_pkg::digit_t DIGIT_MAX  = {bdsm_pkg::DIGIT_W{1'b1}};
    localparam int               ROW_COUNT  = 16;
    localparam int               RAND_BEATS = 900;
    localparam int               IDLE_PCT   = 37;
    localparam int               DRAIN_CYC  = 12;

    // One row of the directed digit table. When chk is set, the expected product
    // digits are typed in and replace the predicted ones.
    typedef struct packed {
        bdsm_pkg::digit_t digit;
        bdsm_pkg::digit_t mult;
        logic             last;
        logic             chk;
        bdsm_pkg::digit_t want_low;
        bdsm_pkg::digit_t want_top;
    } digit_row_t;

    // One expected output beat.
    typedef struct packed {
        bdsm_pkg::digit_t digit;
        logic             top;
    } product_beat_t;

    logic                             clk;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [bdsm_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // in_digit[51:0], multiplier[103:52]
    logic                             s_axis_tlast;   // last_digit
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [bdsm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // out_digit[51:0], zero pad[55:52]
    logic                             m_axis_tlast;   // out_last

    digit_row_t       digit_rows [ROW_COUNT];
    product_beat_t    product_q [$];
    product_beat_t    seen_want;
    bdsm_pkg::digit_t carry_digit;      // predictor copy of the pending carry digit
    int               fail_count;
    int               beats_sent;
    logic             calm;             // high: neither side inserts idle cycles

    bignum_digit_scalar_multiply dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs on either handshake.
    initial
    begin
        #5ms;
        $display("** bignum_digit_scalar_multiply: FAILED **");
        $finish;
    end

    // Random 52-bit digit, biased toward the corners of the digit range.
    function automatic bdsm_pkg::digit_t pick_digit();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DIGIT_MAX;
            2:       return bdsm_pkg::digit_t'($urandom_range(0, 255));
            3:       return bdsm_pkg::digit_t'(1) << $urandom_range(0, bdsm_pkg::DIGIT_W - 1);
            4:       return DIGIT_MAX - bdsm_pkg::digit_t'($urandom_range(0, 255));
            default: return r[bdsm_pkg::DIGIT_W-1:0];
        endcase
    endfunction

    // Advance the carry digit by one input digit and form the product digits.
    // top_digit only matters when last is set; the carry then clears.
    task automatic step_product(input bdsm_pkg::digit_t d, input bdsm_pkg::digit_t m,
                                input logic last, output bdsm_pkg::digit_t low_digit,
                                output bdsm_pkg::digit_t top_digit);
        logic [2*bdsm_pkg::DIGIT_W-1:0] prod;
        bdsm_pkg::digit_carry_t         sum;
        prod        = {{bdsm_pkg::DIGIT_W{1'b0}}, d} * {{bdsm_pkg::DIGIT_W{1'b0}}, m};
        sum         = {1'b0, prod[bdsm_pkg::DIGIT_W-1:0]} + {1'b0, carry_digit};
        low_digit   = sum[bdsm_pkg::DIGIT_W-1:0];
        carry_digit = prod[2*bdsm_pkg::DIGIT_W-1:bdsm_pkg::DIGIT_W]
                    + bdsm_pkg::digit_t'(sum[bdsm_pkg::DIGIT_W]);
        top_digit   = carry_digit;
        if (last)
            carry_digit = '0;
    endtask

    // Present one input beat, starting and ending at a falling edge. Idle cycles
    // carry junk on tdata so the block cannot lean on stale data.
    task automatic send_digit(input bdsm_pkg::digit_t d, input bdsm_pkg::digit_t m,
                              input logic last, input logic chk,
                              input bdsm_pkg::digit_t want_low,
                              input bdsm_pkg::digit_t want_top);
        bdsm_pkg::digit_t low_d;
        bdsm_pkg::digit_t top_d;
        product_beat_t    b;
        logic [127:0]     junk;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            junk          = {$urandom, $urandom, $urandom, $urandom};
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= junk[bdsm_pkg::IN_TDATA_W-1:0];
            s_axis_tlast  <= junk[127];
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {m, d};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // Beat accepted at this edge: queue what it produces.
        step_product(d, m, last, low_d, top_d);
        if (chk)
        begin
            low_d = want_low;
            top_d = want_top;
        end
        b.digit = low_d;
        b.top   = 1'b0;
        product_q.push_back(b);
        if (last)
        begin
            b.digit = top_d;
            b.top   = 1'b1;
            product_q.push_back(b);
        end
        beats_sent++;
        @(negedge clk);
    endtask

    // Receiver: stall at random, except during the calm stretch.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Check every accepted output beat against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (product_q.size() == 0)
            begin
                $error("unexpected output beat: out_digit %h out_last %b",
                       m_axis_tdata[bdsm_pkg::DIGIT_W-1:0], m_axis_tlast);
                fail_count++;
            end
            else
            begin
                seen_want = product_q.pop_front();
                if (m_axis_tdata[bdsm_pkg::DIGIT_W-1:0] !== seen_want.digit)
                begin
                    $error("out_digit: expected %h, got %h", seen_want.digit,
                           m_axis_tdata[bdsm_pkg::DIGIT_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tlast !== seen_want.top)
                begin
                    $error("out_last: expected %b, got %b", seen_want.top, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tdata[bdsm_pkg::OUT_TDATA_W-1:bdsm_pkg::DIGIT_W] !== '0)
                begin
                    $error("tdata pad: expected %h, got %h", {bdsm_pkg::OUT_PAD_W{1'b0}},
                           m_axis_tdata[bdsm_pkg::OUT_TDATA_W-1:bdsm_pkg::DIGIT_W]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int               len;
        int               k;
        bdsm_pkg::digit_t mult;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        calm          = 1'b0;
        carry_digit   = '0;
        fail_count    = 0;
        beats_sent    = 0;

        // Corners with the answer written out; carry starts at zero after reset.
        digit_rows[0]  = '{'0, '0, 1'b1, 1'b1, '0, '0};
        digit_rows[1]  = '{DIGIT_MAX, DIGIT_MAX, 1'b1, 1'b1, 52'h1, 52'hFFFFFFFFFFFFE};
        digit_rows[2]  = '{DIGIT_MAX, 52'h1, 1'b1, 1'b1, DIGIT_MAX, '0};
        digit_rows[3]  = '{52'h1, DIGIT_MAX, 1'b1, 1'b1, DIGIT_MAX, '0};
        // Multi-digit number: largest carry digit, then a carry out of the sum.
        digit_rows[4]  = '{DIGIT_MAX, DIGIT_MAX, 1'b0, 1'b1, 52'h1, '0};
        digit_rows[5]  = '{DIGIT_MAX, DIGIT_MAX, 1'b0, 1'b1, DIGIT_MAX, '0};
        digit_rows[6]  = '{DIGIT_MAX, 52'h1, 1'b0, 1'b1, 52'hFFFFFFFFFFFFD, '0};
        digit_rows[7]  = '{'0, DIGIT_MAX, 1'b1, 1'b1, 52'h1, '0};
        // Bit patterns and a multiplier that changes inside one number.
        digit_rows[8]  = '{52'hAAAAAAAAAAAAA, 52'h5555555555555, 1'b0, 1'b0, '0, '0};
        digit_rows[9]  = '{52'h5555555555555, 52'hAAAAAAAAAAAAA, 1'b0, 1'b0, '0, '0};
        digit_rows[10] = '{52'h8000000000000, 52'h8000000000000, 1'b0, 1'b0, '0, '0};
        digit_rows[11] = '{52'h0000000000001, 52'h8000000000000, 1'b1, 1'b0, '0, '0};
        digit_rows[12] = '{52'h00000075BCD15, 52'h000003ADE68B1, 1'b0, 1'b0, '0, '0};
        digit_rows[13] = '{DIGIT_MAX, 52'h000003ADE68B1, 1'b0, 1'b0, '0, '0};
        digit_rows[14] = '{52'h7FFFFFFFFFFFF, 52'hFFFFFFFFFFFF0, 1'b0, 1'b0, '0, '0};
        digit_rows[15] = '{52'h0F0F0F0F0F0F0, 52'hF0F0F0F0F0F0F, 1'b1, 1'b0, '0, '0};

        // Hold reset, then release it on a falling edge.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int r = 0; r < ROW_COUNT; r++)
            send_digit(digit_rows[r].digit, digit_rows[r].mult, digit_rows[r].last,
                       digit_rows[r].chk, digit_rows[r].want_low, digit_rows[r].want_top);

        // Random numbers: mostly short, some long, a few single-digit. The
        // multiplier holds per number but now and then changes mid-number.
        while (beats_sent < ROW_COUNT + RAND_BEATS)
        begin
            calm = (beats_sent >= ROW_COUNT + 350) && (beats_sent < ROW_COUNT + 500);
            case ($urandom_range(0, 19))
                0:       len = 1;
                1, 2, 3: len = $urandom_range(7, 20);
                default: len = $urandom_range(1, 6);
            endcase
            mult = pick_digit();
            for (k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 11) == 0)
                    mult = pick_digit();
                send_digit(pick_digit(), mult, k == len - 1, 1'b0, '0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        // Drain the expected beats, then give the pipeline time to show extras.
        while (product_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (fail_count == 0 && product_q.size() == 0)
            $display("** bignum_digit_scalar_multiply: PASSED **");
        else
            $display("** bignum_digit_scalar_multiply: FAILED **");
        $finish;
    end

endmodule
